// File: rtl/acdp_pkg.sv
`default_nettype none
package acdp_pkg;

	localparam int VALUE_WIDTH = 32;
	localparam int OUT_WIDTH   = 32;
	localparam int SUM_W       = VALUE_WIDTH + 5;

	localparam logic signed [SUM_W-1:0] SUM_HI = {{6{1'b0}}, {(VALUE_WIDTH-1){1'b1}}};
	localparam logic signed [SUM_W-1:0] SUM_LO = {{6{1'b1}}, {(VALUE_WIDTH-1){1'b0}}};

	localparam int QDEPTH = 4;
	localparam int QAW    = $clog2(QDEPTH);

	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_MINUS = 8'h2d;
	localparam logic [7:0] CH_PLUS  = 8'h2b;

	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_NONE   = 2'd1;
	localparam logic [1:0] ST_SYNTAX = 2'd2;
	localparam logic [1:0] ST_OVF    = 2'd3;

	typedef struct packed {
		logic       has_char;
		logic       eos;
		logic       ws;
		logic       zero;
		logic       digit;
		logic       sign;
		logic       neg;
		logic [3:0] dval;
	} class_t;

	typedef enum logic [5:0] {
		PH_START  = 6'b000001,
		PH_ZEROS  = 6'b000010,
		PH_SIGN   = 6'b000100,
		PH_DIGITS = 6'b001000,
		PH_DONE   = 6'b010000,
		PH_ERROR  = 6'b100000
	} phase_t;

endpackage
`default_nettype wire

// File: rtl/acdp_front.sv
`default_nettype none
module acdp_front
	import acdp_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       push,
	output logic            full,
	input  wire logic [7:0] char_code,
	input  wire logic       has_char,
	input  wire logic       end_of_string,
	output logic            head_valid,
	output class_t          head_item,
	input  wire logic       head_pop
);

	class_t            entry_q [QDEPTH];
	logic [QAW-1:0]    wr_q;
	logic [QAW-1:0]    rd_q;
	logic [QAW:0]      cnt_q;
	class_t            cls;
	logic              accept;
	logic              wr_en;
	logic              rd_en;

	always_comb begin
		cls.has_char = has_char;
		cls.eos      = end_of_string;
		cls.ws       = (char_code == CH_SPACE) || (char_code == CH_TAB);
		cls.zero     = (char_code == CH_ZERO);
		cls.digit    = (char_code >= CH_ZERO) && (char_code <= CH_NINE);
		cls.sign     = (char_code == CH_MINUS) || (char_code == CH_PLUS);
		cls.neg      = (char_code == CH_MINUS);
		cls.dval     = char_code[3:0];
	end

	assign full       = (cnt_q == (QAW+1)'(QDEPTH));
	assign accept     = push && !full;
	// drop beats that carry neither a character nor an end mark
	assign wr_en      = accept && (has_char || end_of_string);
	assign head_valid = (cnt_q != '0);
	assign head_item  = entry_q[rd_q];
	assign rd_en      = head_pop && head_valid;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			entry_q[wr_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (wr_en) begin
				wr_q <= wr_q + 1'b1;
			end
			if (rd_en) begin
				rd_q <= rd_q + 1'b1;
			end
			if (wr_en && !rd_en) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (!wr_en && rd_en) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

// File: rtl/acdp_back.sv
`default_nettype none
module acdp_back
	import acdp_pkg::*;
(
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        head_valid,
	input  wire class_t                      head_item,
	output logic                             head_pop,
	input  wire logic                        cfg_valid,
	input  wire logic signed [OUT_WIDTH-1:0] default_value,
	input  wire logic                        pop,
	output logic                             empty,
	output logic signed [OUT_WIDTH-1:0]      parsed_value,
	output logic [1:0]                       parse_status
);

	phase_t                         phase_q, phase_n;
	logic signed [VALUE_WIDTH-1:0]  acc_q, acc_n;
	logic                           seen_q, seen_n;
	logic                           neg_q, neg_n;
	logic                           ovf_q, ovf_n;
	logic signed [OUT_WIDTH-1:0]    default_q;
	logic                           res_valid_q;
	logic signed [OUT_WIDTH-1:0]    value_q;
	logic [1:0]                     status_q;

	logic signed [SUM_W-1:0]        accx;
	logic signed [SUM_W-1:0]        prod;
	logic signed [SUM_W-1:0]        dx;
	logic signed [SUM_W-1:0]        sum;
	logic                           sum_ovf;
	logic                           do_add;
	logic                           advance;
	logic signed [OUT_WIDTH-1:0]    value_n;
	logic [1:0]                     status_n;

	// hold only an end-of-string beat while a result waits
	assign advance  = head_valid && (!head_item.eos || !res_valid_q || pop);
	assign head_pop = advance;
	assign empty        = !res_valid_q;
	assign parsed_value = value_q;
	assign parse_status = status_q;

	always_comb begin
		accx    = SUM_W'(acc_q);
		prod    = (accx <<< 3) + (accx <<< 1);
		dx      = SUM_W'({1'b0, head_item.dval});
		sum     = neg_q ? (prod - dx) : (prod + dx);
		sum_ovf = (sum > SUM_HI) || (sum < SUM_LO);
	end

	always_comb begin
		phase_n = phase_q;
		seen_n  = seen_q;
		neg_n   = neg_q;
		do_add  = 1'b0;
		if (head_item.has_char) begin
			unique case (phase_q)
				PH_START: begin
					if (head_item.ws) begin
						phase_n = PH_START;
					end else if (head_item.zero) begin
						phase_n = PH_ZEROS;
						seen_n  = 1'b1;
					end else if (head_item.sign) begin
						phase_n = PH_SIGN;
						neg_n   = head_item.neg;
					end else if (head_item.digit) begin
						phase_n = PH_DIGITS;
						seen_n  = 1'b1;
						do_add  = 1'b1;
					end else begin
						phase_n = PH_ERROR;
					end
				end
				PH_ZEROS: begin
					if (head_item.ws) begin
						phase_n = PH_DONE;
					end else if (head_item.zero) begin
						phase_n = PH_ZEROS;
					end else if (head_item.digit) begin
						phase_n = PH_DIGITS;
						do_add  = 1'b1;
					end else begin
						phase_n = PH_ERROR;
					end
				end
				PH_SIGN: begin
					if (head_item.zero) begin
						phase_n = PH_ZEROS;
						seen_n  = 1'b1;
					end else if (head_item.digit) begin
						phase_n = PH_DIGITS;
						seen_n  = 1'b1;
						do_add  = 1'b1;
					end else begin
						phase_n = PH_ERROR;
					end
				end
				PH_DIGITS: begin
					if (head_item.digit) begin
						do_add = 1'b1;
					end else begin
						phase_n = PH_DONE;
					end
				end
				default: begin
					phase_n = phase_q;
				end
			endcase
		end
		acc_n = acc_q;
		ovf_n = ovf_q;
		if (do_add && !ovf_q) begin
			if (sum_ovf) begin
				ovf_n = 1'b1;
			end else begin
				acc_n = sum[VALUE_WIDTH-1:0];
			end
		end
		if (phase_n == PH_ERROR) begin
			status_n = ST_SYNTAX;
			value_n  = default_q;
		end else if (ovf_n) begin
			status_n = ST_OVF;
			value_n  = default_q;
		end else if (seen_n) begin
			status_n = ST_OK;
			value_n  = OUT_WIDTH'(acc_n);
		end else begin
			status_n = ST_NONE;
			value_n  = default_q;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && head_item.eos) begin
			value_q  <= value_n;
			status_q <= status_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_START;
			acc_q       <= '0;
			seen_q      <= 1'b0;
			neg_q       <= 1'b0;
			ovf_q       <= 1'b0;
			default_q   <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				default_q <= default_value;
			end
			if (advance) begin
				if (head_item.eos) begin
					phase_q <= PH_START;
					acc_q   <= '0;
					seen_q  <= 1'b0;
					neg_q   <= 1'b0;
					ovf_q   <= 1'b0;
				end else begin
					phase_q <= phase_n;
					acc_q   <= acc_n;
					seen_q  <= seen_n;
					neg_q   <= neg_n;
					ovf_q   <= ovf_n;
				end
			end
			if (advance && head_item.eos) begin
				res_valid_q <= 1'b1;
			end else if (pop) begin
				res_valid_q <= 1'b0;
			end
		end
	end

endmodule
`default_nettype wire

// File: rtl/ascii_decimal_to_int_parser.sv
`default_nettype none
// A result is registered on the result ports when its end-of-string beat leaves the head of
// the queue; the beat is first written into a queue entry.
// Throughput: one character per cycle while the queue is not full, set by the combinational
// times-ten-and-add step. A four-entry queue sits between the classifier and the parser;
// a held result stalls the next end-of-string beat at the queue head and the beats behind it.
// Reset (arst_n low, asynchronous) empties both sides, clears the parse state and sets the
// default value to zero; the block takes input from the first cycle after reset.
module ascii_decimal_to_int_parser
	import acdp_pkg::*;
(
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        push,
	output logic                             full,
	input  wire logic [7:0]                  char_code,
	input  wire logic                        has_char,
	input  wire logic                        end_of_string,
	output logic                             empty,
	input  wire logic                        pop,
	output logic signed [OUT_WIDTH-1:0]      parsed_value,
	output logic [1:0]                       parse_status,
	input  wire logic                        cfg_valid,
	output logic                             cfg_ready,
	input  wire logic signed [OUT_WIDTH-1:0] default_value
);

	logic   head_valid;
	logic   head_pop;
	class_t head_item;

	assign cfg_ready = 1'b1;

	acdp_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (push),
		.full          (full),
		.char_code     (char_code),
		.has_char      (has_char),
		.end_of_string (end_of_string),
		.head_valid    (head_valid),
		.head_item     (head_item),
		.head_pop      (head_pop)
	);

	acdp_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head_valid    (head_valid),
		.head_item     (head_item),
		.head_pop      (head_pop),
		.cfg_valid     (cfg_valid),
		.default_value (default_value),
		.pop           (pop),
		.empty         (empty),
		.parsed_value  (parsed_value),
		.parse_status  (parse_status)
	);

endmodule
`default_nettype wire

// File: tb/sv/parse_result_checker.sv
module parse_result_checker
	import acdp_pkg::*;
(
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        push,
	input  wire logic                        full,
	input  wire logic [7:0]                  char_code,
	input  wire logic                        has_char,
	input  wire logic                        end_of_string,
	input  wire logic                        empty,
	input  wire logic                        pop,
	input  wire logic signed [OUT_WIDTH-1:0] parsed_value,
	input  wire logic [1:0]                  parse_status,
	input  wire logic                        cfg_valid,
	input  wire logic                        cfg_ready,
	input  wire logic signed [OUT_WIDTH-1:0] cfg_data,
	output int                               mismatches,
	output int                               outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam longint VAL_MAX = (VALUE_WIDTH >= 64) ? 64'sh7fff_ffff_ffff_ffff :
		(longint'(1) << (VALUE_WIDTH - 1)) - 1;
	localparam longint VAL_MIN = -VAL_MAX - 1;

	typedef struct {
		logic signed [OUT_WIDTH-1:0] value;
		logic [1:0]                  status;
	} parse_result_t;

	parse_result_t               expected_q[$];
	parse_result_t               oldest;
	phase_t                      phase;
	longint                      acc;
	bit                          number_seen;
	bit                          minus_seen;
	bit                          overflow_seen;
	logic signed [OUT_WIDTH-1:0] dflt;

	function automatic void clear_string();
		phase = PH_START;
		acc = 0;
		number_seen = 1'b0;
		minus_seen = 1'b0;
		overflow_seen = 1'b0;
	endfunction

	function automatic void accumulate_digit(input logic [7:0] c);
		longint d;
		d = longint'(c - CH_ZERO);
		if (overflow_seen)
			return;
		if (!minus_seen) begin
			if (acc > (VAL_MAX - d) / 10)
				overflow_seen = 1'b1;
			else
				acc = acc * 10 + d;
		end else begin
			if (acc < (VAL_MIN + d) / 10)
				overflow_seen = 1'b1;
			else
				acc = acc * 10 - d;
		end
	endfunction

	function automatic void advance_parse(input logic [7:0] c);
		bit ws;
		bit digit;
		bit zero;
		bit sign;
		ws = (c == CH_SPACE) || (c == CH_TAB);
		digit = (c >= CH_ZERO) && (c <= CH_NINE);
		zero = (c == CH_ZERO);
		sign = (c == CH_MINUS) || (c == CH_PLUS);
		case (phase)
			PH_START: begin
				if (ws) begin
					phase = PH_START;
				end else if (zero) begin
					phase = PH_ZEROS;
					number_seen = 1'b1;
				end else if (sign) begin
					phase = PH_SIGN;
					minus_seen = (c == CH_MINUS);
				end else if (digit) begin
					phase = PH_DIGITS;
					number_seen = 1'b1;
					accumulate_digit(c);
				end else begin
					phase = PH_ERROR;
				end
			end
			PH_ZEROS: begin
				if (ws) begin
					phase = PH_DONE;
				end else if (zero) begin
					phase = PH_ZEROS;
				end else if (digit) begin
					phase = PH_DIGITS;
					accumulate_digit(c);
				end else begin
					phase = PH_ERROR;
				end
			end
			PH_SIGN: begin
				if (zero) begin
					phase = PH_ZEROS;
					number_seen = 1'b1;
				end else if (digit) begin
					phase = PH_DIGITS;
					number_seen = 1'b1;
					accumulate_digit(c);
				end else begin
					phase = PH_ERROR;
				end
			end
			PH_DIGITS: begin
				if (digit)
					accumulate_digit(c);
				else
					phase = PH_DONE;
			end
			default: ;
		endcase
	endfunction

	function automatic void finish_string();
		parse_result_t r;
		r.value = dflt;
		if (phase == PH_ERROR)
			r.status = ST_SYNTAX;
		else if (overflow_seen)
			r.status = ST_OVF;
		else if (number_seen) begin
			r.status = ST_OK;
			r.value = OUT_WIDTH'(acc);
		end else
			r.status = ST_NONE;
		expected_q.push_back(r);
		clear_string();
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_string();
			dflt = '0;
			expected_q.delete();
			mismatches = 0;
			outstanding = 0;
		end else begin
			if (cfg_valid && cfg_ready)
				dflt = cfg_data;
			if (pop && !empty) begin
				if (expected_q.size() == 0) begin
					mismatches++;
					$display("%0t: unexpected result, expected none, actual value %0d status %0d",
						$time, parsed_value, parse_status);
				end else begin
					oldest = expected_q.pop_front();
					if (parsed_value !== oldest.value) begin
						mismatches++;
						$display("%0t: parsed_value expected %0d actual %0d",
							$time, oldest.value, parsed_value);
					end
					if (parse_status !== oldest.status) begin
						mismatches++;
						$display("%0t: parse_status expected %0d actual %0d",
							$time, oldest.status, parse_status);
					end
				end
			end
			if (push && !full) begin
				if (has_char)
					advance_parse(char_code);
				if (end_of_string)
					finish_string();
			end
			outstanding = expected_q.size();
		end
	end

endmodule

// File: tb/sv/tb_ascii_decimal_to_int_parser.sv
module tb_ascii_decimal_to_int_parser
	import acdp_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int STALL_LIMIT = 2000;
	localparam int HOLD_CYCLES = 200;
	localparam int PHASE_CHARS = 120;

	logic                        clk = 1'b0;
	logic                        arst_n;
	logic                        push;
	logic                        full;
	logic [7:0]                  char_code;
	logic                        has_char;
	logic                        end_of_string;
	logic                        empty;
	logic                        pop;
	logic signed [OUT_WIDTH-1:0] parsed_value;
	logic [1:0]                  parse_status;
	logic                        cfg_valid;
	logic                        cfg_ready;
	logic signed [OUT_WIDTH-1:0] default_value;

	int         mismatches;
	int         outstanding;
	int         tx_idle_pct = 0;
	int         rx_stall_pct = 0;
	bit         rx_hold_req = 1'b0;
	int         chars_sent = 0;
	int         quiet_cycles = 0;
	logic [7:0] text_q[$];

	always #10 clk = ~clk;

	ascii_decimal_to_int_parser dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (push),
		.full          (full),
		.char_code     (char_code),
		.has_char      (has_char),
		.end_of_string (end_of_string),
		.empty         (empty),
		.pop           (pop),
		.parsed_value  (parsed_value),
		.parse_status  (parse_status),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.default_value (default_value)
	);

	parse_result_checker checker_i (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (push),
		.full          (full),
		.char_code     (char_code),
		.has_char      (has_char),
		.end_of_string (end_of_string),
		.empty         (empty),
		.pop           (pop),
		.parsed_value  (parsed_value),
		.parse_status  (parse_status),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (default_value),
		.mismatches    (mismatches),
		.outstanding   (outstanding)
	);

	always @(posedge clk) begin
		if (!arst_n || (push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("ascii_decimal_to_int_parser: mismatch");
			$finish;
		end
	end

	initial begin
		pop = 1'b0;
		forever begin
			@(negedge clk);
			if (rx_hold_req) begin
				pop <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				rx_hold_req = 1'b0;
			end
			pop <= ($urandom_range(99) >= rx_stall_pct);
		end
	end

	task automatic put_beat(input logic [7:0] c, input logic hc, input logic eos);
		@(negedge clk);
		while ($urandom_range(99) < tx_idle_pct) begin
			push <= 1'b0;
			char_code <= 8'($urandom);
			has_char <= 1'($urandom);
			end_of_string <= 1'($urandom);
			@(negedge clk);
		end
		push <= 1'b1;
		char_code <= c;
		has_char <= hc;
		end_of_string <= eos;
		do @(posedge clk); while (full);
		if (hc)
			chars_sent++;
	endtask

	// hold the channel until the block has drained
	task automatic settle();
		@(negedge clk);
		push <= 1'b0;
		while (outstanding != 0) @(negedge clk);
		repeat (10) @(negedge clk);
	endtask

	task automatic write_default(input logic signed [OUT_WIDTH-1:0] v);
		@(negedge clk);
		cfg_valid <= 1'b1;
		default_value <= v;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic send_text(input bit fill, input bit bare_end);
		int n;
		n = text_q.size();
		for (int i = 0; i < n; i++) begin
			if (fill && $urandom_range(19) == 0)
				put_beat(8'($urandom), 1'b0, 1'b0);
			put_beat(text_q[i], 1'b1, !bare_end && i == n - 1);
		end
		if (bare_end || n == 0)
			put_beat(8'($urandom), 1'b0, 1'b1);
		text_q.delete();
	endtask

	function automatic void load_text(input string t);
		for (int i = 0; i < t.len(); i++)
			text_q.push_back(t[i]);
	endfunction

	function automatic void push_decimal(input longint unsigned mag);
		logic [7:0] digs[$];
		if (mag == 0)
			digs.push_back(CH_ZERO);
		while (mag != 0) begin
			digs.push_front(CH_ZERO + 8'(mag % 10));
			mag = mag / 10;
		end
		foreach (digs[i])
			text_q.push_back(digs[i]);
	endfunction

	function automatic logic [7:0] pick_char();
		case ($urandom_range(7))
			0: return CH_SPACE;
			1: return CH_TAB;
			2: return CH_MINUS;
			3: return CH_PLUS;
			4: return CH_ZERO;
			5: return CH_ZERO + 8'($urandom_range(1, 9));
			6: return CH_NINE;
			default: return 8'($urandom);
		endcase
	endfunction

	function automatic void build_random_string();
		int kind;
		longint unsigned mag;
		kind = $urandom_range(9);
		text_q.delete();
		if (kind <= 5) begin
			repeat ($urandom_range(2))
				text_q.push_back($urandom_range(1) ? CH_SPACE : CH_TAB);
			case ($urandom_range(2))
				1: text_q.push_back(CH_PLUS);
				2: text_q.push_back(CH_MINUS);
				default: ;
			endcase
			if ($urandom_range(2) == 0)
				repeat ($urandom_range(1, 2)) text_q.push_back(CH_ZERO);
			case ($urandom_range(3))
				0: mag = $urandom_range(999);
				1: mag = $urandom;
				2: mag = 64'd2147483645 + $urandom_range(5);
				default: mag = longint'($urandom) * $urandom_range(1, 5);
			endcase
			push_decimal(mag);
			if ($urandom_range(2) == 0)
				repeat ($urandom_range(1, 3)) text_q.push_back(pick_char());
		end else if (kind <= 7) begin
			repeat ($urandom_range(1, 5)) text_q.push_back(pick_char());
		end else begin
			repeat ($urandom_range(1, 4)) text_q.push_back(8'($urandom));
		end
	endfunction

	task automatic random_phase(input int idle_pct, input int stall_pct);
		int target;
		target = chars_sent + PHASE_CHARS;
		tx_idle_pct = idle_pct;
		rx_stall_pct = stall_pct;
		while (chars_sent < target) begin
			build_random_string();
			send_text(1'b1, $urandom_range(7) == 0);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		push = 1'b0;
		char_code = '0;
		has_char = 1'b0;
		end_of_string = 1'b0;
		cfg_valid = 1'b0;
		default_value = '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		load_text("0");
		send_text(1'b0, 1'b0);
		load_text("-00");
		send_text(1'b0, 1'b0);
		load_text("+");
		send_text(1'b0, 1'b0);
		load_text("\t");
		send_text(1'b0, 1'b0);
		load_text("-+");
		send_text(1'b0, 1'b0);
		load_text("0-");
		send_text(1'b0, 1'b0);
		load_text("- ");
		send_text(1'b0, 1'b0);
		load_text("0 9");
		send_text(1'b0, 1'b0);
		load_text("00x");
		send_text(1'b0, 1'b0);
		text_q.push_back(8'hff);
		send_text(1'b0, 1'b0);
		send_text(1'b0, 1'b1);
		put_beat("5", 1'b1, 1'b0);
		put_beat(8'h00, 1'b0, 1'b0);
		put_beat("3", 1'b1, 1'b1);

		settle();
		write_default(32'sh8000_0000);
		random_phase(0, 0);
		settle();
		write_default(32'sh7fff_ffff);
		random_phase(74, 0);
		settle();
		write_default(32'($urandom));
		random_phase(0, 74);
		settle();
		write_default(-32'sd1);
		random_phase(36, 36);
		settle();
		write_default('0);

		// fill the block while results are held back
		tx_idle_pct = 0;
		rx_stall_pct = 0;
		rx_hold_req = 1'b1;
		repeat (30) begin
			text_q.push_back(CH_ZERO + 8'($urandom_range(9)));
			send_text(1'b0, 1'b0);
		end
		settle();

		if (mismatches == 0 && outstanding == 0)
			$display("ascii_decimal_to_int_parser: match");
		else
			$display("ascii_decimal_to_int_parser: mismatch");
		$finish;
	end

endmodule

// File: filelist.f
rtl/acdp_pkg.sv
rtl/acdp_front.sv
rtl/acdp_back.sv
rtl/ascii_decimal_to_int_parser.sv
tb/sv/parse_result_checker.sv
tb/sv/tb_ascii_decimal_to_int_parser.sv
